// ===== src/sfifo_pkg.sv =====
// ----------------------------------------------------------------------------
// sfifo_pkg: shared types and constants for the searchable fifo
// Sizes of the entry row, request kinds, status codes and the per-cell
// control bundle.
// ----------------------------------------------------------------------------
package sfifo_pkg;

   // size of the entry row and of one stored entry
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // request and response field widths
   localparam int VALUE_W = 32;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 5;

   typedef logic [DATA_WIDTH-1:0] entry_type;
   typedef logic [CNT_W-1:0]      count_type;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_SEARCH = 2'd3
   } kind_type;

   // response status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   // control handed to each cell of the row
   typedef struct packed {
      logic occupied;   // cell index below the fill count
      logic tail;       // cell index equals the fill count
      logic insert;     // an insert transfer; when the row is full no cell is the tail
      logic remove;     // a remove transfer that hit somewhere in the row
   } cell_ctl_type;

   // sign-extend or truncate the request value to the stored width
   function automatic entry_type to_entry(input logic signed [VALUE_W-1:0] value);
      to_entry = DATA_WIDTH'(value);
   endfunction

endpackage

// ===== src/sfifo_cell.sv =====
// ----------------------------------------------------------------------------
// sfifo_cell: one slot of the entry row
// Holds one entry, compares it against the key, passes the first-match flag
// on to the next cell and shifts the right neighbor in when a remove closes
// a gap at or after the first match.
// ----------------------------------------------------------------------------
module sfifo_cell
   import sfifo_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    key,
   input  entry_type    next_entry,    // entry of the right neighbor
   input  logic         match_in,      // a cell to the left already matched
   output logic         match_out,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      hit;

   // compare, only meaningful inside the filled part
   assign hit       = ctl.occupied && (entry_ff == key);
   assign match_out = match_in | hit;

   // append at the tail or shift left from the first match onward
   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert && ctl.tail) begin
         entry_in = key;
      end else if (ctl.remove && match_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== src/searchable_fifo_with_remove.sv =====
// ----------------------------------------------------------------------------
// searchable_fifo_with_remove: ordered queue with search and remove by value
// A row of DEPTH cells keeps the queue packed from the front. Each request
// is insert, remove first match, clear or search, and answers with a status,
// a found flag and the occupancy after the operation.
// ----------------------------------------------------------------------------
// Usage
//    req_ channel: tuser carries the request kind, tdata the 32-bit value.
//    rsp_ channel: tuser carries status and found, tdata the occupancy.
//    Every request transfer yields exactly one response transfer, in order.
// Response and throughput
//    A response is registered and appears in the cycle after its request
//    transfer. One request is taken every cycle while no held response
//    stalls; all cells compare in parallel and shift in the same cycle, so
//    the first-match chain sets the rate and the next request sees the updated row at once.
// Reset
//    Reset empties the queue and drops any pending response. Entry storage
//    is not cleared; only the fill count is.
// Stall
//    The response register holds while rsp_tready is low; a new request is
//    taken in the cycle the held response leaves, so back-pressure costs
//    no bubble.
// ----------------------------------------------------------------------------
module searchable_fifo_with_remove
   import sfifo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] value
   input  logic [1:0]  req_tuser,    // [1:0] kind
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [4:0] occupancy, [7:5] zero
   output logic [2:0]  rsp_tuser     // [1:0] status, [2] found
);

   count_type    count_ff, count_in;
   logic         rsp_valid_ff, rsp_valid_in;
   status_type   status_ff, status_in;
   logic         found_ff, found_in;
   logic [OCC_W-1:0] occ_ff, occ_in;

   logic         req_xfer;
   kind_type     kind;
   entry_type    key;
   logic         any_match;
   logic         is_empty;
   logic         is_full;

   logic         match_chain [DEPTH+1];
   entry_type    entry_row   [DEPTH];
   cell_ctl_type ctl_row     [DEPTH];

   // request decode
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign key        = to_entry(req_tdata);
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CNT_W'(DEPTH));

   // row of cells, first-match flag runs from the front
   assign match_chain[0] = 1'b0;
   assign any_match      = match_chain[DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign ctl_row[i].occupied = (count_ff > CNT_W'(i));
      assign ctl_row[i].tail     = (count_ff == CNT_W'(i));
      assign ctl_row[i].insert   = req_xfer && (kind == KIND_INSERT);
      assign ctl_row[i].remove   = req_xfer && (kind == KIND_REMOVE) && any_match;

      sfifo_cell u_cell (
         .clock      (clock),
         .ctl        (ctl_row[i]),
         .key        (key),
         .next_entry ((i + 1 < DEPTH) ? entry_row[(i + 1) % DEPTH] : entry_row[i]),
         .match_in   (match_chain[i]),
         .match_out  (match_chain[i+1]),
         .entry      (entry_row[i])
      );
   end

   // operation result and next fill count
   always_comb begin
      count_in  = count_ff;
      status_in = STAT_OK;
      found_in  = 1'b0;
      case (kind)
         KIND_INSERT: begin
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_REMOVE: begin
            if (is_empty) begin
               status_in = STAT_EMPTY;
            end else if (any_match) begin
               found_in = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = STAT_NOT_FOUND;
            end
         end
         KIND_CLEAR: begin
            if (is_empty) begin
               status_in = STAT_EMPTY;
            end
            count_in = '0;
         end
         KIND_SEARCH: begin
            if (is_empty) begin
               status_in = STAT_EMPTY;
            end else if (any_match) begin
               found_in = 1'b1;
            end else begin
               status_in = STAT_NOT_FOUND;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
      occ_in = OCC_W'(count_in);
   end

   // response handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            count_ff <= count_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, occ_ff};
   assign rsp_tuser  = {found_ff, status_ff};

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the searchable fifo with remove
// Directed requests cover the empty queue, a full row with overflow and
// duplicate values, first-match removal and clear. Random traffic follows in
// fill, drain and search phases. A queue model predicts each response and a
// checker compares every response transfer in order.
// ----------------------------------------------------------------------------
module tb_top
   import sfifo_pkg::*;
;

   // expected response of one request
   typedef struct {
      status_type             status;
      logic                   found;
      logic [OCC_W-1:0]       occupancy;
   } queue_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;     // [31:0] value
   logic [1:0]  req_tuser = '0;     // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [4:0] occupancy, [7:5] zero
   logic [2:0]  rsp_tuser;          // [1:0] status, [2] found

   // queue model and outcomes still to arrive
   entry_type         held_entries[$];
   queue_outcome_type pending_outcomes[$];
   int                mismatch_count = 0;
   bit                steady_flow = 1'b0;

   searchable_fifo_with_remove DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock generation
   initial begin
      forever #4 clock = ~clock;
   end

   // overall time limit
   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // print one line per mismatch and keep count
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // index of the first held entry equal to key, or -1
   function automatic int first_match_index(input entry_type key);
      for (int i = 0; i < held_entries.size(); i++) begin
         if (held_entries[i] == key)
            return i;
      end
      return -1;
   endfunction

   // apply one request to the queue model and return its response
   function automatic queue_outcome_type apply_queue_request(input kind_type kind,
                                                             input logic [31:0] raw);
      queue_outcome_type res;
      entry_type         key;
      int                pos;
      key = DATA_WIDTH'($signed(raw));
      res.status = STAT_OK;
      res.found  = 1'b0;
      case (kind)
         KIND_INSERT: begin
            if (held_entries.size() >= DEPTH)
               res.status = STAT_FULL;
            else
               held_entries.push_back(key);
         end
         KIND_REMOVE: begin
            if (held_entries.size() == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               pos = first_match_index(key);
               if (pos < 0) begin
                  res.status = STAT_NOT_FOUND;
               end else begin
                  held_entries.delete(pos);
                  res.found = 1'b1;
               end
            end
         end
         KIND_CLEAR: begin
            if (held_entries.size() == 0)
               res.status = STAT_EMPTY;
            held_entries.delete();
         end
         default: begin
            if (held_entries.size() == 0)
               res.status = STAT_EMPTY;
            else if (first_match_index(key) >= 0)
               res.found = 1'b1;
            else
               res.status = STAT_NOT_FOUND;
         end
      endcase
      res.occupancy = OCC_W'(held_entries.size());
      return res;
   endfunction

   // send one request: random idle cycles, then hold until the transfer
   task automatic send_request(input kind_type kind, input logic [31:0] value);
      while (!steady_flow && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= 2'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do
         @(posedge clock);
      while (!req_tready);
      pending_outcomes.push_back(apply_queue_request(kind, value));
      @(negedge clock);
   endtask

   // response side back-pressure
   always @(negedge clock) begin
      rsp_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 36);
   end

   // compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      queue_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with none expected", rsp_tuser, 0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tuser[1:0] !== want.status)
               report_mismatch("status", rsp_tuser[1:0], want.status);
            if (rsp_tuser[2] !== want.found)
               report_mismatch("found", rsp_tuser[2], want.found);
            if (rsp_tdata !== {3'b000, want.occupancy})
               report_mismatch("occupancy", rsp_tdata, want.occupancy);
         end
      end
   end

   // remove, search and clear on an empty queue
   task automatic test_empty_queue();
      send_request(KIND_REMOVE, 32'h0000_0000);
      send_request(KIND_SEARCH, 32'hFFFF_FFFF);
      send_request(KIND_CLEAR, 32'hA5A5_A5A5);
   endtask

   // fill the row with extremes and duplicates, then overflow it
   task automatic test_fill_and_overflow();
      send_request(KIND_INSERT, 32'h8000_0000);
      send_request(KIND_INSERT, 32'h7FFF_FFFF);
      send_request(KIND_INSERT, 32'h0000_0000);
      send_request(KIND_INSERT, 32'hFFFF_FFFF);
      send_request(KIND_INSERT, 32'h0000_0001);
      send_request(KIND_INSERT, 32'h0000_0005);
      send_request(KIND_INSERT, 32'hFFFF_FFFF);
      send_request(KIND_INSERT, 32'h0000_0005);
      for (int i = 0; i < DEPTH - 8; i++)
         send_request(KIND_INSERT, $urandom);
      // full queue drops the value
      send_request(KIND_INSERT, 32'h1234_5678);
   endtask

   // first-match removal and lookup hits and misses
   task automatic test_match_rules();
      send_request(KIND_SEARCH, 32'h7FFF_FFFF);
      send_request(KIND_REMOVE, 32'hFFFF_FFFF);
      send_request(KIND_SEARCH, 32'h1357_9BDF);
      send_request(KIND_REMOVE, 32'h1357_9BDF);
   endtask

   // clear of a non-empty queue
   task automatic test_clear();
      send_request(KIND_CLEAR, 32'h0000_0000);
   endtask

   // operand mixing hits on held entries, a small pool and extremes
   function automatic logic [31:0] pick_operand();
      int r;
      r = $urandom_range(99);
      if (r < 40 && held_entries.size() > 0)
         return held_entries[$urandom_range(held_entries.size() - 1)];
      if (r < 60)
         return 32'($signed($urandom_range(7)) - 3);
      if (r < 70) begin
         case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   // random traffic in fill, drain and search phases
   task automatic test_random_traffic();
      kind_type kind;
      int       r;
      for (int phase = 0; phase < 19; phase++) begin
         // one long stretch runs without any idling
         steady_flow = (phase == 6 || phase == 7);
         for (int n = 0; n < 100; n++) begin
            r = $urandom_range(99);
            if (r < 2)
               kind = KIND_CLEAR;
            else if (phase % 3 == 0)
               kind = (r < 65) ? KIND_INSERT : (r < 85) ? KIND_REMOVE : KIND_SEARCH;
            else if (phase % 3 == 1)
               kind = (r < 30) ? KIND_INSERT : (r < 80) ? KIND_REMOVE : KIND_SEARCH;
            else
               kind = (r < 45) ? KIND_INSERT : (r < 65) ? KIND_REMOVE : KIND_SEARCH;
            send_request(kind, pick_operand());
         end
      end
      steady_flow = 1'b0;
   endtask

   // reset, tests in turn, drain and verdict
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_queue();
      test_fill_and_overflow();
      test_match_rules();
      test_clear();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
